[hdl/rpi_pkg.sv]
// Shared widths, opcodes and helper functions for the ray against polygon unit.
// Used by ray_polygon_intersect_unit and its checker; depends on nothing.
package rpi_pkg;

  localparam int unsigned CW      = 32;   // coordinate width
  localparam int unsigned EW      = CW + 1; // edge and offset delta width
  localparam int unsigned AW      = 100;  // accumulator and dividend width
  localparam int unsigned DW      = 66;   // divisor magnitude width
  localparam int unsigned RW      = 34;   // square root remainder width
  localparam int unsigned SW      = 2 * EW; // square root operand width
  localparam int unsigned CNTW    = 7;
  localparam int unsigned IN_DW   = 6 * CW;
  localparam int unsigned OUT_DW  = 3 * CW;

  localparam logic [CNTW-1:0] MAC_LAST = CNTW'(EW - 1);
  localparam logic [CNTW-1:0] DIV_LAST = CNTW'(AW - 1);
  localparam logic [CNTW-1:0] SQ_LAST  = CNTW'(EW - 1);

  typedef enum logic {
    OP_BEGIN  = 1'b0,
    OP_VERTEX = 1'b1
  } opcode_e;

  typedef logic signed [AW-1:0] acc_t;

  function automatic acc_t sext_c(input logic [CW-1:0] v);
    sext_c = {{(AW - CW){v[CW-1]}}, v};
  endfunction

  function automatic acc_t sext_e(input logic [EW-1:0] v);
    sext_e = {{(AW - EW){v[EW-1]}}, v};
  endfunction

  // Saturate a wide signed value to the signed coordinate range.
  function automatic logic [CW-1:0] clamp_c(input acc_t s);
    logic fits;
    fits = (&s[AW-1:CW-1]) | ~(|s[AW-1:CW-1]);
    if (fits) begin
      clamp_c = s[CW-1:0];
    end else if (s[AW-1]) begin
      clamp_c = {1'b1, {(CW - 1){1'b0}}};
    end else begin
      clamp_c = {1'b0, {(CW - 1){1'b1}}};
    end
  endfunction

  // True when |s| <= 2^CW - 1.
  function automatic logic mag_fits(input acc_t s);
    mag_fits = ~(|s[AW-1:CW]) | ((&s[AW-1:CW]) & (|s[CW-1:0]));
  endfunction

endpackage

[hdl/ray_polygon_intersect_unit.sv]
// Ray against polygon test, first edge hit wins, exact integer arithmetic.
// Each edge test runs up to ten shift-and-add MAC passes, restoring divides for
// the x and y offsets and a square root; a closing vertex also tests the edge
// back to the first vertex. No new word is taken until the current one is done.
// Reset (rst_ni low, asynchronous) clears the ray, the polygon state and the output.
module ray_polygon_intersect_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // ray_x, ray_y, dir_x, dir_y, vertex_x, vertex_y
  input  logic [rpi_pkg::IN_DW-1:0]  s_axis_tdata_i,
  // opcode
  input  logic                       s_axis_tuser_i,
  input  logic                       s_axis_tlast_i,
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  // point_x, point_y, distance
  output logic [rpi_pkg::OUT_DW-1:0] m_axis_tdata_o,
  // hit
  output logic                       m_axis_tuser_o
);
  import rpi_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SETUP, S_MAC, S_NEXT, S_DIVP, S_DIV, S_DIVE,
    S_PX, S_PY, S_DCHK, S_SQRT, S_SQE, S_AFTER, S_EMIT
  } state_e;

  typedef enum logic [3:0] {
    P_DEN1, P_DEN2, P_TN1, P_TN2, P_UN1, P_UN2, P_NX, P_NY, P_SX, P_SY
  } prod_e;

  state_e state_q;
  prod_e  prod_q;

  logic [CW-1:0] ox_q, oy_q, hx_q, hy_q, fx_q, fy_q, pvx_q, pvy_q;
  logic [CW-1:0] sx_q, sy_q, ex_q, ey_q;
  logic [EW-1:0] edx_q, edy_q, rx_q, ry_q;
  logic          seen_q, found_q, last_q, closing_q;
  logic [CW-1:0] hpx_q, hpy_q, hdist_q;
  acc_t          acc_q, a_q, den_q, tn_q, offx_q, offy_q;
  logic [EW-1:0] b_q;
  logic          sub_q;
  logic [CNTW-1:0] cnt_q;
  logic [AW-1:0] dvd_q;
  logic [DW-1:0] dmag_q, rem_q;
  logic          qneg_q, divy_q;
  logic [SW-1:0] sq_q;
  logic [RW-1:0] srem_q;
  logic [EW-1:0] root_q;
  logic          mv_q, mhit_q;
  logic [CW-1:0] mpx_q, mpy_q, mdist_q;

  logic [CW-1:0] vx, vy;
  logic          s_fire;
  acc_t          mac_term, mac_sum, acc_abs, quo, pt_sum, un_lim;
  logic          mac_neg, un_bad;
  logic [DW:0]   div_sh, div_diff;
  logic [RW+1:0] sq_sh, sq_trial, sq_diff;
  logic [EW-1:0] edge_x, edge_y;

  assign vx     = s_axis_tdata_i[5*CW-1:4*CW];
  assign vy     = s_axis_tdata_i[6*CW-1:5*CW];
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_fire = s_axis_tvalid_i & s_axis_tready_o;

  always_comb begin
    mac_term = b_q[0] ? a_q : '0;
    mac_neg  = sub_q ^ (cnt_q == MAC_LAST);
    mac_sum  = mac_neg ? acc_q - mac_term : acc_q + mac_term;
    acc_abs  = acc_q[AW-1] ? -acc_q : acc_q;
    quo      = qneg_q ? -acc_t'(dvd_q) : acc_t'(dvd_q);
    div_sh   = {rem_q, dvd_q[AW-1]};
    div_diff = div_sh - {1'b0, dmag_q};
    sq_sh    = {srem_q, sq_q[SW-1:SW-2]};
    sq_trial = {1'b0, root_q, 2'b01};
    sq_diff  = sq_sh - sq_trial;
    pt_sum   = (state_q == S_PY) ? sext_c(oy_q) + offy_q : sext_c(ox_q) + offx_q;
    edge_x   = {sx_q[CW-1], sx_q} - {ex_q[CW-1], ex_q};
    edge_y   = {sy_q[CW-1], sy_q} - {ey_q[CW-1], ey_q};
    un_lim   = den_q[AW-1] ? -(acc_q - den_q) : (acc_q - den_q);
    // same sign as den is checked separately; here flag |un| >= |den|
    un_bad   = den_q[AW-1] ? ~(un_lim[AW-1]) : ~(un_lim[AW-1]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;   prod_q <= P_DEN1;
      ox_q <= '0; oy_q <= '0; hx_q <= '0; hy_q <= '0;
      fx_q <= '0; fy_q <= '0; pvx_q <= '0; pvy_q <= '0;
      sx_q <= '0; sy_q <= '0; ex_q <= '0; ey_q <= '0;
      edx_q <= '0; edy_q <= '0; rx_q <= '0; ry_q <= '0;
      seen_q <= 1'b0; found_q <= 1'b0; last_q <= 1'b0; closing_q <= 1'b0;
      hpx_q <= '0; hpy_q <= '0; hdist_q <= '0;
      acc_q <= '0; a_q <= '0; den_q <= '0; tn_q <= '0; offx_q <= '0; offy_q <= '0;
      b_q <= '0; sub_q <= 1'b0; cnt_q <= '0;
      dvd_q <= '0; dmag_q <= '0; rem_q <= '0; qneg_q <= 1'b0; divy_q <= 1'b0;
      sq_q <= '0; srem_q <= '0; root_q <= '0;
      mv_q <= 1'b0; mhit_q <= 1'b0; mpx_q <= '0; mpy_q <= '0; mdist_q <= '0;
    end else begin
      if (mv_q && m_axis_tready_i && state_q != S_EMIT) begin
        mv_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (s_fire) begin
            if (s_axis_tuser_i == OP_BEGIN) begin
              ox_q <= s_axis_tdata_i[CW-1:0];
              oy_q <= s_axis_tdata_i[2*CW-1:CW];
              hx_q <= s_axis_tdata_i[3*CW-1:2*CW];
              hy_q <= s_axis_tdata_i[4*CW-1:3*CW];
              seen_q <= 1'b0; found_q <= 1'b0;
              hpx_q <= '0; hpy_q <= '0; hdist_q <= '0;
            end else begin
              last_q <= s_axis_tlast_i;
              closing_q <= 1'b0;
              pvx_q <= vx; pvy_q <= vy;
              sx_q <= pvx_q; sy_q <= pvy_q; ex_q <= vx; ey_q <= vy;
              if (!seen_q) begin
                fx_q <= vx; fy_q <= vy; seen_q <= 1'b1;
                state_q <= S_AFTER;
              end else if (found_q) begin
                state_q <= S_AFTER;
              end else begin
                state_q <= S_SETUP;
              end
            end
          end
        end
        S_SETUP: begin
          edx_q <= edge_x; edy_q <= edge_y;
          rx_q <= {ox_q[CW-1], ox_q} - {sx_q[CW-1], sx_q};
          ry_q <= {oy_q[CW-1], oy_q} - {sy_q[CW-1], sy_q};
          acc_q <= '0; a_q <= sext_e(edge_x); b_q <= {hy_q[CW-1], hy_q};
          sub_q <= 1'b0; cnt_q <= '0; prod_q <= P_DEN1;
          state_q <= S_MAC;
        end
        S_MAC: begin
          acc_q <= mac_sum;
          a_q <= a_q <<< 1;
          b_q <= b_q >> 1;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == MAC_LAST) begin
            state_q <= S_NEXT;
          end
        end
        S_NEXT: begin
          cnt_q <= '0;
          state_q <= S_MAC;
          case (prod_q)
            P_DEN1: begin
              a_q <= sext_e(edy_q); b_q <= {hx_q[CW-1], hx_q}; sub_q <= 1'b1;
              prod_q <= P_DEN2;
            end
            P_DEN2: begin
              den_q <= acc_q;
              dmag_q <= acc_abs[DW-1:0];
              if (acc_q == '0) begin
                state_q <= S_AFTER;
              end else begin
                acc_q <= '0; a_q <= sext_e(rx_q); b_q <= edy_q; sub_q <= 1'b0;
                prod_q <= P_TN1;
              end
            end
            P_TN1: begin
              a_q <= sext_e(ry_q); b_q <= edx_q; sub_q <= 1'b1;
              prod_q <= P_TN2;
            end
            P_TN2: begin
              tn_q <= acc_q;
              if (acc_q == '0 || acc_q[AW-1] != den_q[AW-1]) begin
                state_q <= S_AFTER;
              end else begin
                acc_q <= '0; a_q <= sext_e(ry_q); b_q <= {hx_q[CW-1], hx_q};
                sub_q <= 1'b0; prod_q <= P_UN1;
              end
            end
            P_UN1: begin
              a_q <= sext_e(rx_q); b_q <= {hy_q[CW-1], hy_q}; sub_q <= 1'b1;
              prod_q <= P_UN2;
            end
            P_UN2: begin
              if (acc_q == '0 || acc_q[AW-1] != den_q[AW-1] || un_bad) begin
                state_q <= S_AFTER;
              end else begin
                acc_q <= '0; a_q <= tn_q; b_q <= {hx_q[CW-1], hx_q};
                sub_q <= 1'b0; prod_q <= P_NX;
              end
            end
            P_NX: begin
              divy_q <= 1'b0;
              state_q <= S_DIVP;
            end
            P_NY: begin
              divy_q <= 1'b1;
              state_q <= S_DIVP;
            end
            P_SX: begin
              a_q <= offy_q; b_q <= offy_q[EW-1:0]; sub_q <= 1'b0;
              prod_q <= P_SY;
            end
            P_SY: begin
              sq_q <= acc_q[SW-1:0];
              srem_q <= '0; root_q <= '0;
              state_q <= S_SQRT;
            end
            default: begin
              state_q <= S_AFTER;
            end
          endcase
        end
        S_DIVP: begin
          dvd_q <= acc_abs;
          qneg_q <= acc_q[AW-1] ^ den_q[AW-1];
          rem_q <= '0; cnt_q <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (!div_diff[DW]) begin
            rem_q <= div_diff[DW-1:0];
            dvd_q <= {dvd_q[AW-2:0], 1'b1};
          end else begin
            rem_q <= div_sh[DW-1:0];
            dvd_q <= {dvd_q[AW-2:0], 1'b0};
          end
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == DIV_LAST) begin
            state_q <= S_DIVE;
          end
        end
        S_DIVE: begin
          if (divy_q) begin
            offy_q <= quo;
            state_q <= S_PX;
          end else begin
            offx_q <= quo;
            acc_q <= '0; a_q <= tn_q; b_q <= {hy_q[CW-1], hy_q};
            sub_q <= 1'b0; cnt_q <= '0; prod_q <= P_NY;
            state_q <= S_MAC;
          end
        end
        S_PX: begin
          hpx_q <= clamp_c(pt_sum);
          state_q <= S_PY;
        end
        S_PY: begin
          hpy_q <= clamp_c(pt_sum);
          state_q <= S_DCHK;
        end
        S_DCHK: begin
          if (!mag_fits(offx_q) || !mag_fits(offy_q)) begin
            hdist_q <= '1;
            found_q <= 1'b1;
            state_q <= S_AFTER;
          end else begin
            acc_q <= '0; a_q <= offx_q; b_q <= offx_q[EW-1:0];
            sub_q <= 1'b0; cnt_q <= '0; prod_q <= P_SX;
            state_q <= S_MAC;
          end
        end
        S_SQRT: begin
          sq_q <= sq_q << 2;
          if (!sq_diff[RW+1]) begin
            srem_q <= sq_diff[RW-1:0];
            root_q <= {root_q[EW-2:0], 1'b1};
          end else begin
            srem_q <= sq_sh[RW-1:0];
            root_q <= {root_q[EW-2:0], 1'b0};
          end
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == SQ_LAST) begin
            state_q <= S_SQE;
          end
        end
        S_SQE: begin
          hdist_q <= root_q[EW-1] ? '1 : root_q[CW-1:0];
          found_q <= 1'b1;
          state_q <= S_AFTER;
        end
        S_AFTER: begin
          if (!last_q) begin
            state_q <= S_IDLE;
          end else if (!closing_q && !found_q) begin
            closing_q <= 1'b1;
            sx_q <= pvx_q; sy_q <= pvy_q; ex_q <= fx_q; ey_q <= fy_q;
            state_q <= S_SETUP;
          end else begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!mv_q || m_axis_tready_i) begin
            mv_q <= 1'b1;
            mhit_q <= found_q;
            mpx_q <= hpx_q; mpy_q <= hpy_q; mdist_q <= hdist_q;
            seen_q <= 1'b0; found_q <= 1'b0;
            hpx_q <= '0; hpy_q <= '0; hdist_q <= '0;
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = mv_q;
  assign m_axis_tuser_o  = mhit_q;
  assign m_axis_tdata_o  = {mdist_q, mpy_q, mpx_q};

endmodule

[hdl/rpi_checker.sv]
// Port-level checker for ray_polygon_intersect_unit, bound to the top level.
// Depends on rpi_pkg.
module rpi_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tvalid_i,
  input logic                       s_axis_tready_o,
  input logic                       s_axis_tuser_i,
  input logic                       s_axis_tlast_i,
  input logic                       m_axis_tvalid_o,
  input logic                       m_axis_tready_i,
  input logic [rpi_pkg::OUT_DW-1:0] m_axis_tdata_o,
  input logic                       m_axis_tuser_o
);
  import rpi_pkg::*;

  logic s_fire;
  assign s_fire = s_axis_tvalid_i & s_axis_tready_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output word dropped or changed while stalled");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o == '0)
    else $error("miss word carries nonzero data");

  a_begin_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && s_axis_tuser_i == OP_BEGIN |=> !$rose(m_axis_tvalid_o))
    else $error("begin word produced a result");

  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && s_axis_tuser_i == OP_VERTEX && s_axis_tlast_i |=> !s_axis_tready_o)
    else $error("ready right after closing vertex");

endmodule

bind ray_polygon_intersect_unit rpi_checker u_rpi_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .s_axis_tlast_i  (s_axis_tlast_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
